>>> hw/rtl/dcc_pkg.sv
package dcc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PREAMBLE_LEN  = 2'd0,
    CFG_IDLE_ADDRESS  = 2'd1,
    CFG_IDLE_DATA     = 2'd2,
    CFG_IDLE_HAS_DATA = 2'd3
  } cfg_idx_e;

  // Packet frame position
  typedef enum logic [2:0] {
    FR_PREAMBLE   = 3'd0,
    FR_START      = 3'd1,
    FR_ADDRESS    = 3'd2,
    FR_DATA_START = 3'd3,
    FR_DATA       = 3'd4,
    FR_ERR_START  = 3'd5,
    FR_ERR        = 3'd6,
    FR_END        = 3'd7
  } frame_e;

  // Half-bit position within the current bit
  typedef enum logic [2:0] {
    HP_ONE_HIGH   = 3'd0,
    HP_ONE_LOW    = 3'd1,
    HP_ZERO_HIGH1 = 3'd2,
    HP_ZERO_HIGH2 = 3'd3,
    HP_ZERO_LOW1  = 3'd4,
    HP_ZERO_LOW2  = 3'd5
  } half_e;

  localparam logic [4:0] RST_PREAMBLE_LEN  = 5'd16;
  localparam logic [7:0] RST_IDLE_ADDRESS  = 8'd3;
  localparam logic [7:0] RST_IDLE_DATA     = 8'h7f;
  localparam logic       RST_IDLE_HAS_DATA = 1'b1;
  localparam int unsigned ByteBits         = 8;

  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic [7:0] address;
  } pkt_t;

  localparam pkt_t RST_IDLE_PKT = '{
    has_data: RST_IDLE_HAS_DATA,
    data:     RST_IDLE_DATA,
    address:  RST_IDLE_ADDRESS
  };

  typedef struct packed {
    logic       func;
    logic [7:0] pkt_address;
    logic [7:0] pkt_data;
    logic       pkt_has_data;
  } in_beat_t;

  typedef struct packed {
    logic       track_polarity;
    logic       enqueue_accepted;
    logic [5:0] queue_level;
    logic       packet_done;
  } out_beat_t;

  // First half-bit of a bit of the given value
  function automatic half_e bit_start(input logic b);
    bit_start = b ? HP_ONE_HIGH : HP_ZERO_HIGH1;
  endfunction

endpackage

>>> hw/rtl/dcc_packet_transmitter_unit.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o   dcc_pkg::in_beat_t  (tick or enqueue)
// out       output     out_valid_o/out_stall_i dcc_pkg::out_beat_t (one per input beat)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A new input beat may enter every cycle while in_stall_o is low; its result is
// registered into the output register, or into the skid while the output is stalled.
// Reset loads the register defaults and two idle packets; the first tick
// drives the first preamble bit high. No clearing pass is needed.
// A two-entry output stage (register plus skid) lets the input keep flowing
// while the output is stalled; in_stall_o rises only once the skid is full.
module dcc_packet_transmitter_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcc_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcc_pkg::out_beat_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import dcc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  // Configuration registers
  logic [4:0] preamble_len_q;
  logic [7:0] idle_address_q;
  logic [7:0] idle_data_q;
  logic       idle_has_data_q;

  // Queue memory and its read path
  pkt_t            mem [QUEUE_DEPTH];
  pkt_t            mem_rd_q;
  logic            fwd_hit_q, fwd_hit_d;
  pkt_t            fwd_data_q;
  logic            slot1_hit_q, slot1_hit_d;
  logic            slot1_init_q, slot1_init_d;
  logic            mem_we;
  logic [PtrW-1:0] wr_addr, rd_addr;
  logic [SumW-1:0] wr_sum;
  pkt_t            wr_pkt, nxt_pkt;

  // Track state
  logic [PtrW-1:0] read_slot_q, read_slot_d;
  logic [CntW-1:0] held_q, held_d;
  frame_e          frame_q, frame_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [4:0]      cnt_inc;
  half_e           half_q, half_d;
  pkt_t            cur_q, cur_d;
  logic [7:0]      err_byte;
  logic            done;
  logic            polarity;

  // Output stage
  logic      in_acc;
  out_beat_t res;
  logic      out_valid_q;
  out_beat_t out_q;
  logic      skid_valid_q;
  out_beat_t skid_q;

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_len_q  <= RST_PREAMBLE_LEN;
      idle_address_q  <= RST_IDLE_ADDRESS;
      idle_data_q     <= RST_IDLE_DATA;
      idle_has_data_q <= RST_IDLE_HAS_DATA;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PREAMBLE_LEN:  preamble_len_q  <= cfg_data_i[4:0];
        CFG_IDLE_ADDRESS:  idle_address_q  <= cfg_data_i;
        CFG_IDLE_DATA:     idle_data_q     <= cfg_data_i;
        CFG_IDLE_HAS_DATA: idle_has_data_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Enqueue lands at read_slot + held, wrapped once
  assign wr_sum  = SumW'(read_slot_q) + SumW'(held_q);
  assign wr_addr = (wr_sum >= SumW'(QUEUE_DEPTH)) ? PtrW'(wr_sum - SumW'(QUEUE_DEPTH))
                                                  : PtrW'(wr_sum);
  // Keep the slot after the current one prefetched
  assign rd_addr = (read_slot_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : read_slot_q + PtrW'(1);

  assign wr_pkt = '{
    has_data: in_data_i.pkt_has_data,
    data:     in_data_i.pkt_data,
    address:  in_data_i.pkt_address
  };

  // Forward a write to the prefetched slot; slot one holds an idle packet until written
  assign fwd_hit_d    = mem_we && (wr_addr == rd_addr);
  assign slot1_hit_d  = slot1_init_q && (rd_addr == PtrW'(1));
  assign slot1_init_d = slot1_init_q && !(mem_we && (wr_addr == PtrW'(1)));
  assign nxt_pkt      = fwd_hit_q   ? fwd_data_q :
                        slot1_hit_q ? RST_IDLE_PKT : mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_pkt;
    end
    mem_rd_q   <= mem[rd_addr];
    fwd_data_q <= wr_pkt;
  end

  assign cnt_inc  = cnt_q + 5'd1;
  assign err_byte = cur_q.address ^ cur_q.data;

  // Next state: enqueue, or advance the half-bit and pick the next bit
  always_comb begin
    half_d      = half_q;
    frame_d     = frame_q;
    cnt_d       = cnt_q;
    read_slot_d = read_slot_q;
    held_d      = held_q;
    cur_d       = cur_q;
    done        = 1'b0;
    mem_we      = 1'b0;
    if (in_acc) begin
      if (in_data_i.func) begin
        if (held_q < CntW'(QUEUE_DEPTH)) begin
          mem_we = 1'b1;
          held_d = held_q + CntW'(1);
        end
      end else begin
        case (half_q)
          HP_ONE_HIGH:   half_d = HP_ONE_LOW;
          HP_ZERO_HIGH1: half_d = HP_ZERO_HIGH2;
          HP_ZERO_HIGH2: half_d = HP_ZERO_LOW1;
          HP_ZERO_LOW1:  half_d = HP_ZERO_LOW2;
          default: begin
            case (frame_q)
              FR_PREAMBLE: begin
                cnt_d  = cnt_inc;
                half_d = HP_ONE_HIGH;
                if (cnt_inc >= preamble_len_q) begin
                  frame_d = FR_START;
                  cnt_d   = '0;
                  half_d  = HP_ZERO_HIGH1;
                end
              end
              FR_START: begin
                frame_d = FR_ADDRESS;
                cnt_d   = '0;
                half_d  = bit_start(cur_q.address[ByteBits-1]);
              end
              FR_ADDRESS: begin
                cnt_d = cnt_inc;
                if (cnt_inc >= 5'(ByteBits)) begin
                  frame_d = cur_q.has_data ? FR_DATA_START : FR_END;
                  half_d  = cur_q.has_data ? HP_ZERO_HIGH1 : HP_ONE_HIGH;
                end else begin
                  half_d = bit_start(cur_q.address[3'd7 - cnt_inc[2:0]]);
                end
              end
              FR_DATA_START: begin
                frame_d = FR_DATA;
                cnt_d   = '0;
                half_d  = bit_start(cur_q.data[ByteBits-1]);
              end
              FR_DATA: begin
                cnt_d = cnt_inc;
                if (cnt_inc >= 5'(ByteBits)) begin
                  frame_d = FR_ERR_START;
                  half_d  = HP_ZERO_HIGH1;
                end else begin
                  half_d = bit_start(cur_q.data[3'd7 - cnt_inc[2:0]]);
                end
              end
              FR_ERR_START: begin
                frame_d = FR_ERR;
                cnt_d   = '0;
                half_d  = bit_start(err_byte[ByteBits-1]);
              end
              FR_ERR: begin
                cnt_d = cnt_inc;
                if (cnt_inc >= 5'(ByteBits)) begin
                  frame_d = FR_END;
                  half_d  = HP_ONE_HIGH;
                end else begin
                  half_d = bit_start(err_byte[3'd7 - cnt_inc[2:0]]);
                end
              end
              default: begin
                // End bit finished: refill with idle or advance to the next slot
                done    = 1'b1;
                frame_d = FR_PREAMBLE;
                cnt_d   = '0;
                half_d  = HP_ONE_HIGH;
                if (held_q <= CntW'(1)) begin
                  held_d = CntW'(1);
                  cur_d  = '{has_data: idle_has_data_q, data: idle_data_q,
                             address: idle_address_q};
                end else begin
                  held_d      = held_q - CntW'(1);
                  read_slot_d = rd_addr;
                  cur_d       = nxt_pkt;
                end
              end
            endcase
          end
        endcase
      end
    end
  end

  // Outputs of the track sequencer
  always_comb begin
    polarity = !in_data_i.func &&
               (half_q inside {HP_ONE_HIGH, HP_ZERO_HIGH1, HP_ZERO_HIGH2});
    res.track_polarity   = polarity;
    res.enqueue_accepted = mem_we;
    res.queue_level      = 6'(held_d);
    res.packet_done      = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_slot_q  <= '0;
      held_q       <= CntW'(2);
      frame_q      <= FR_PREAMBLE;
      cnt_q        <= '0;
      half_q       <= HP_ONE_HIGH;
      cur_q        <= RST_IDLE_PKT;
      fwd_hit_q    <= 1'b0;
      slot1_hit_q  <= 1'b0;
      slot1_init_q <= 1'b1;
    end else begin
      read_slot_q  <= read_slot_d;
      held_q       <= held_d;
      frame_q      <= frame_d;
      cnt_q        <= cnt_d;
      half_q       <= half_d;
      cur_q        <= cur_d;
      fwd_hit_q    <= fwd_hit_d;
      slot1_hit_q  <= slot1_hit_d;
      slot1_init_q <= slot1_init_d;
    end
  end

  // Output register with skid: hold while stalled, park one extra beat in the skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (in_acc) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dcc_pkg::*;

  localparam int unsigned QDEPTH      = 32;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic        OP_TICK     = 1'b0;
  localparam logic        OP_ENQUEUE  = 1'b1;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  dcc_packet_transmitter_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shared control between the stimulus, the receiver and the checker
  bit quiet;     // suppress all random idling on both sides
  bit hold_req;  // ask the receiver for one long hold-off
  int errors;

  // Track results still owed by the block, oldest first
  out_beat_t track_beats_q[$];

  // Shadow of the encoder: register copies, packet ring and bit position
  logic [4:0]  pre_len;
  logic [7:0]  idle_addr;
  logic [7:0]  idle_dat;
  logic        idle_has;
  pkt_t        ring_q [QDEPTH];
  int unsigned rd_slot;
  int unsigned held;
  frame_e      frame;
  logic [4:0]  bit_cnt;
  half_e       half;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous ceiling on the whole run
  initial begin
    #5ms;
    $display("dcc_packet_transmitter_unit test failed");
    $finish;
  end

  // First half-bit of a byte bit, counted MSB first
  function automatic half_e bit_head(input logic [7:0] val, input int idx);
    return val[7 - idx] ? HP_ONE_HIGH : HP_ZERO_HIGH1;
  endfunction

  // A bit has just finished: move through the frame and pick the next bit
  function automatic half_e advance_frame(output logic done);
    pkt_t       pk;
    logic [7:0] chk;
    pk   = ring_q[rd_slot];
    chk  = pk.address ^ pk.data;
    done = 1'b0;
    case (frame)
      FR_PREAMBLE: begin
        // a zero length still sends one preamble bit
        bit_cnt = bit_cnt + 5'd1;
        if (bit_cnt >= pre_len) begin
          frame   = FR_START;
          bit_cnt = '0;
          return HP_ZERO_HIGH1;
        end
        return HP_ONE_HIGH;
      end
      FR_START: begin
        frame   = FR_ADDRESS;
        bit_cnt = '0;
        return bit_head(pk.address, 0);
      end
      FR_ADDRESS: begin
        bit_cnt = bit_cnt + 5'd1;
        if (bit_cnt >= 5'd8) begin
          if (pk.has_data) begin
            frame = FR_DATA_START;
            return HP_ZERO_HIGH1;
          end
          frame = FR_END;
          return HP_ONE_HIGH;
        end
        return bit_head(pk.address, int'(bit_cnt));
      end
      FR_DATA_START: begin
        frame   = FR_DATA;
        bit_cnt = '0;
        return bit_head(pk.data, 0);
      end
      FR_DATA: begin
        bit_cnt = bit_cnt + 5'd1;
        if (bit_cnt >= 5'd8) begin
          frame = FR_ERR_START;
          return HP_ZERO_HIGH1;
        end
        return bit_head(pk.data, int'(bit_cnt));
      end
      FR_ERR_START: begin
        frame   = FR_ERR;
        bit_cnt = '0;
        return bit_head(chk, 0);
      end
      FR_ERR: begin
        bit_cnt = bit_cnt + 5'd1;
        if (bit_cnt >= 5'd8) begin
          frame = FR_END;
          return HP_ONE_HIGH;
        end
        return bit_head(chk, int'(bit_cnt));
      end
      default: begin
        // End bit finished: retire the packet, or refill the slot with idle
        done    = 1'b1;
        frame   = FR_PREAMBLE;
        bit_cnt = '0;
        if (held <= 1) begin
          held = 1;
          ring_q[rd_slot] = '{has_data: idle_has, data: idle_dat, address: idle_addr};
        end else begin
          held    = held - 1;
          rd_slot = (rd_slot + 1) % QDEPTH;
        end
        return HP_ONE_HIGH;
      end
    endcase
  endfunction

  // Work out the track result of one accepted input beat
  function automatic out_beat_t track_step(input in_beat_t b);
    out_beat_t r;
    logic      done;
    r    = '0;
    done = 1'b0;
    if (b.func == OP_ENQUEUE) begin
      // a full ring drops the packet silently apart from the flag
      if (held < QDEPTH) begin
        ring_q[(rd_slot + held) % QDEPTH] =
          '{has_data: b.pkt_has_data, data: b.pkt_data, address: b.pkt_address};
        held = held + 1;
        r.enqueue_accepted = 1'b1;
      end
    end else begin
      r.track_polarity = half inside {HP_ONE_HIGH, HP_ZERO_HIGH1, HP_ZERO_HIGH2};
      case (half)
        HP_ONE_HIGH:   half = HP_ONE_LOW;
        HP_ZERO_HIGH1: half = HP_ZERO_HIGH2;
        HP_ZERO_HIGH2: half = HP_ZERO_LOW1;
        HP_ZERO_LOW1:  half = HP_ZERO_LOW2;
        default:       half = advance_frame(done);
      endcase
      r.packet_done = done;
    end
    r.queue_level = 6'(held);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Checker: retire output beats first, then log config writes and new
  // input beats, all sampled at the same edge so nothing hangs on ordering
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want_beat;
    if (!rst_ni) begin
      pre_len   = RST_PREAMBLE_LEN;
      idle_addr = RST_IDLE_ADDRESS;
      idle_dat  = RST_IDLE_DATA;
      idle_has  = RST_IDLE_HAS_DATA;
      foreach (ring_q[i]) ring_q[i] = '0;
      ring_q[0] = RST_IDLE_PKT;
      ring_q[1] = RST_IDLE_PKT;
      rd_slot   = 0;
      held      = 2;
      frame     = FR_PREAMBLE;
      bit_cnt   = '0;
      half      = HP_ONE_HIGH;
      track_beats_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (track_beats_q.size() == 0) begin
          $display("%0t: output beat with nothing owed, expected none, actual %p",
                   $time, out_data_o);
          errors++;
        end else begin
          want_beat = track_beats_q.pop_front();
          check_field("track_polarity", 8'(want_beat.track_polarity),
                      8'(out_data_o.track_polarity));
          check_field("enqueue_accepted", 8'(want_beat.enqueue_accepted),
                      8'(out_data_o.enqueue_accepted));
          check_field("queue_level", 8'(want_beat.queue_level),
                      8'(out_data_o.queue_level));
          check_field("packet_done", 8'(want_beat.packet_done),
                      8'(out_data_o.packet_done));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PREAMBLE_LEN:  pre_len   = cfg_data_i[4:0];
          CFG_IDLE_ADDRESS:  idle_addr = cfg_data_i;
          CFG_IDLE_DATA:     idle_dat  = cfg_data_i;
          CFG_IDLE_HAS_DATA: idle_has  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) track_beats_q.push_back(track_step(in_data_i));
    end
  end

  // Receiver: sparse random stalls, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Offer one beat and hold it until the block takes it; valid stays high
  // afterwards so back-to-back beats need no drop
  task automatic send_beat(input in_beat_t b);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic in_beat_t rand_beat(input int enq_pct);
    in_beat_t b;
    b.func         = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_TICK;
    b.pkt_address  = 8'($urandom);
    b.pkt_data     = 8'($urandom);
    b.pkt_has_data = 1'($urandom);
    return b;
  endfunction

  task automatic run_random(input int n, input int enq_pct);
    repeat (n) send_beat(rand_beat(enq_pct));
  endtask

  // Drop valid, wait for every owed beat, then let the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (track_beats_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Program all four registers; only called with the block idle
  task automatic set_track_config(input logic [4:0] pre, input logic [7:0] addr,
                                  input logic [7:0] dat, input logic has);
    write_reg(CFG_PREAMBLE_LEN, 8'(pre));
    write_reg(CFG_IDLE_ADDRESS, addr);
    write_reg(CFG_IDLE_DATA, dat);
    write_reg(CFG_IDLE_HAS_DATA, 8'(has));
    cfg_valid_i <= 1'b0;
  endtask

  // Reset defaults: first preamble halves, enqueue extremes, more ticks
  task automatic test_directed_beats();
    repeat (6) send_beat('{func: OP_TICK, pkt_address: 8'h00, pkt_data: 8'h00,
                           pkt_has_data: 1'b0});
    send_beat('{func: OP_ENQUEUE, pkt_address: 8'h00, pkt_data: 8'h00, pkt_has_data: 1'b0});
    send_beat('{func: OP_ENQUEUE, pkt_address: 8'hff, pkt_data: 8'hff, pkt_has_data: 1'b1});
    send_beat('{func: OP_ENQUEUE, pkt_address: 8'h80, pkt_data: 8'h01, pkt_has_data: 1'b1});
    send_beat('{func: OP_ENQUEUE, pkt_address: 8'h7f, pkt_data: 8'hfe, pkt_has_data: 1'b0});
    repeat (14) send_beat('{func: OP_TICK, pkt_address: 8'hff, pkt_data: 8'hff,
                            pkt_has_data: 1'b1});
    wait_drained();
  endtask

  // Zero preamble length sends a single preamble bit; idle packet all zeros
  task automatic test_short_preamble();
    set_track_config(5'd0, 8'h00, 8'h00, 1'b0);
    run_random(140, 2);
    wait_drained();
  endtask

  // Longest preamble, idle all ones, no idling on either side
  task automatic test_long_preamble();
    quiet = 1'b1;
    set_track_config(5'd31, 8'hff, 8'hff, 1'b1);
    run_random(140, 2);
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_mid_settings();
    set_track_config(5'd10, 8'($urandom), 8'($urandom), 1'($urandom));
    run_random(140, 4);
    wait_drained();
  endtask

  // Receiver holds off while beats keep coming: block must stall its input
  task automatic test_back_pressure();
    hold_req = 1'b1;
    run_random(30, 10);
    wait_drained();
  endtask

  // Burst of enqueues past the ring depth, then ticks to drain some
  task automatic test_queue_full();
    in_beat_t b;
    set_track_config(5'd12, 8'($urandom), 8'($urandom), 1'b1);
    repeat (45) begin
      b      = rand_beat(0);
      b.func = OP_ENQUEUE;
      send_beat(b);
    end
    run_random(60, 5);
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    errors      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_beats();
    test_short_preamble();
    test_long_preamble();
    test_mid_settings();
    test_back_pressure();
    test_queue_full();

    repeat (10) @(posedge clk_i);
    if (errors == 0 && track_beats_q.size() == 0) begin
      $display("dcc_packet_transmitter_unit test passed");
    end else begin
      $display("dcc_packet_transmitter_unit test failed");
    end
    $finish;
  end

endmodule
